// ===== rtl/core/adf_pkg.sv =====
// shared types and constants for the advertisement duplicate filter
`timescale 1ns / 1ps

package adf_pkg;

    localparam int ADDR_W    = 48;
    localparam int LEN_W     = 5;
    localparam int WORD_W    = 64;
    localparam int TIME_W    = 48;
    localparam int MAXAGE_W  = 16;
    localparam int AGE_W     = 36;
    localparam int REG_IDX_W = 1;
    localparam int PADDR_W   = REG_IDX_W + 2;
    localparam int APB_W     = 32;

    localparam logic [AGE_W-1:0]     US_PER_SECOND   = AGE_W'(1000000);
    localparam logic [REG_IDX_W-1:0] REG_FILTER_EN   = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_AGE     = 1'd1;
    localparam logic                 FILTER_EN_RESET = 1'b1;
    localparam logic [MAXAGE_W-1:0]  MAX_AGE_RESET   = 16'd10;

    // controller to datapath
    typedef struct packed {
        logic cap;
        logic clear;
        logic sweep;
        logic look;
        logic cmp;
        logic scan;
        logic write;
    } adf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic enabled;
        logic dup;
        logic scan_need;
        logic scan_last;
    } adf_sts_t;

endpackage

// ===== rtl/core/adf_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module adf_ram #(
    parameter int WIDTH = 248,
    parameter int DEPTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/adf_ctrl.sv =====
// sequencing state machine and result register of the duplicate filter
`timescale 1ns / 1ps

module adf_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_drop,
    output adf_pkg::adf_cmd_t cmd,
    input  adf_pkg::adf_sts_t sts
);

    import adf_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SWEEP = 3'd1;
    localparam logic [2:0] S_LOOK  = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       drop_pend_reg, drop_pend_next;
    logic       m_valid_reg, m_valid_next;
    logic       m_drop_reg, m_drop_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_drop  = m_drop_reg;

    always_comb begin
        state_next     = state_reg;
        drop_pend_next = drop_pend_reg;
        m_valid_next   = m_valid_reg & ~m_ready;
        m_drop_next    = m_drop_reg;
        cmd            = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.cap = 1'b1;
                    if (!sts.enabled) begin
                        cmd.clear      = 1'b1;
                        drop_pend_next = 1'b0;
                        state_next     = S_DONE;
                    end else begin
                        state_next = S_SWEEP;
                    end
                end
            end
            S_SWEEP: begin
                cmd.sweep  = 1'b1;
                state_next = S_LOOK;
            end
            S_LOOK: begin
                cmd.look   = 1'b1;
                state_next = S_CMP;
            end
            S_CMP: begin
                cmd.cmp = 1'b1;
                if (sts.dup) begin
                    drop_pend_next = 1'b1;
                    state_next     = S_DONE;
                end else begin
                    drop_pend_next = 1'b0;
                    state_next     = sts.scan_need ? S_SCAN : S_WRITE;
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_last) begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                cmd.write  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                // wait for the result register to free up
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_drop_next  = drop_pend_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            drop_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            m_drop_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            drop_pend_reg <= drop_pend_next;
            m_valid_reg   <= m_valid_next;
            m_drop_reg    <= m_drop_next;
        end
    end

endmodule

// ===== rtl/core/adf_dpath.sv =====
// entry table, age checks, lookup, oldest-entry scan and config registers
`timescale 1ns / 1ps

module adf_dpath #(
    parameter int TABLE_ENTRIES     = 16,
    parameter int MAX_PAYLOAD_BYTES = 31
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  adf_pkg::adf_cmd_t              cmd,
    output adf_pkg::adf_sts_t              sts,
    input  logic [adf_pkg::ADDR_W-1:0]     s_device_address,
    input  logic [adf_pkg::LEN_W-1:0]      s_payload_length,
    input  logic [adf_pkg::WORD_W-1:0]     s_payload_word0,
    input  logic [adf_pkg::WORD_W-1:0]     s_payload_word1,
    input  logic [adf_pkg::WORD_W-1:0]     s_payload_word2,
    input  logic [adf_pkg::WORD_W-1:0]     s_payload_word3,
    input  logic [adf_pkg::TIME_W-1:0]     s_now_us,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [adf_pkg::PADDR_W-1:0]    paddr,
    input  logic [adf_pkg::APB_W-1:0]      pwdata,
    output logic [adf_pkg::APB_W-1:0]      prdata
);

    import adf_pkg::*;

    localparam int N     = TABLE_ENTRIES;
    localparam int IDX_W = (N > 1) ? $clog2(N) : 1;
    localparam int PAY_W = MAX_PAYLOAD_BYTES * 8;
    localparam int DIF_W = TIME_W + 1;

    // config
    logic                  en_reg;
    logic [MAXAGE_W-1:0]   max_age_reg;
    logic [AGE_W-1:0]      age_reg;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  cfg_wr;

    // captured beat
    logic [ADDR_W-1:0]     addr_q_reg;
    logic [LEN_W-1:0]      len_q_reg;
    logic [PAY_W-1:0]      pay_q_reg;
    logic [TIME_W-1:0]     now_q_reg;
    logic [LEN_W-1:0]      len_sat;
    logic [PAY_W-1:0]      pay_in;
    logic [4*WORD_W-1:0]   in_bytes;

    // table
    logic [N-1:0]          valid_reg;
    logic [ADDR_W-1:0]     ent_addr_reg [N];
    logic [LEN_W-1:0]      ent_len_reg  [N];
    logic [TIME_W-1:0]     ent_seen_reg [N];
    logic [TIME_W-1:0]     last_sweep_reg;

    // lane results
    logic [N-1:0]          older, younger, match, len_eq;
    logic [DIF_W-1:0]      lane_diff [N];
    logic [DIF_W-1:0]      sweep_diff;
    logic                  sweep_due;

    // lookup
    logic                  hit_found_c, free_found_c;
    logic [IDX_W-1:0]      hit_idx_c, free_idx_c;
    logic                  hit_found_reg, free_found_reg, hit_young_reg, hit_len_eq_reg;
    logic [IDX_W-1:0]      hit_idx_reg, free_idx_reg;
    logic [PAY_W-1:0]      rd_pay;

    // oldest-entry scan
    logic [IDX_W-1:0]      slot_reg;
    logic [IDX_W-1:0]      scan_cnt_reg;
    logic [TIME_W-1:0]     min_time_reg;
    logic [TIME_W-1:0]     scan_time;

    // ---------------- config port
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg      <= FILTER_EN_RESET;
            max_age_reg <= MAX_AGE_RESET;
            age_reg     <= AGE_W'(MAX_AGE_RESET) * US_PER_SECOND;
        end else if (cfg_wr) begin
            if (reg_idx == REG_FILTER_EN) begin
                en_reg <= pwdata[0];
            end else if (reg_idx == REG_MAX_AGE) begin
                max_age_reg <= pwdata[MAXAGE_W-1:0];
                age_reg     <= AGE_W'(pwdata[MAXAGE_W-1:0]) * US_PER_SECOND;
            end
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FILTER_EN: prdata = APB_W'(en_reg);
            REG_MAX_AGE:   prdata = APB_W'(max_age_reg);
            default:       prdata = '0;
        endcase
    end

    // ---------------- capture with length saturation and byte masking
    assign in_bytes = {s_payload_word3, s_payload_word2, s_payload_word1, s_payload_word0};
    assign len_sat  = ({1'b0, s_payload_length} > (LEN_W + 1)'(MAX_PAYLOAD_BYTES))
                      ? LEN_W'(MAX_PAYLOAD_BYTES) : s_payload_length;

    always_comb begin
        for (int b = 0; b < MAX_PAYLOAD_BYTES; b++) begin
            pay_in[b*8 +: 8] = ((LEN_W + 1)'(b) < {1'b0, len_sat}) ? in_bytes[b*8 +: 8] : 8'h00;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            addr_q_reg <= s_device_address;
            len_q_reg  <= len_sat;
            pay_q_reg  <= pay_in;
            now_q_reg  <= s_now_us;
        end
    end

    // ---------------- per-entry age and key checks
    always_comb begin
        for (int i = 0; i < N; i++) begin
            lane_diff[i] = {1'b0, now_q_reg} - {1'b0, ent_seen_reg[i]};
            // negative age counts as young and never as old
            older[i]   = !lane_diff[i][DIF_W-1] &&
                         (lane_diff[i][TIME_W-1:0] > TIME_W'(age_reg));
            younger[i] = lane_diff[i][DIF_W-1] ||
                         (lane_diff[i][TIME_W-1:0] < TIME_W'(age_reg));
            match[i]   = valid_reg[i] && (ent_addr_reg[i] == addr_q_reg);
            len_eq[i]  = (ent_len_reg[i] == len_q_reg);
        end
    end

    assign sweep_diff = {1'b0, now_q_reg} - {1'b0, last_sweep_reg};
    assign sweep_due  = !sweep_diff[DIF_W-1] &&
                        (sweep_diff[TIME_W-1:0] > TIME_W'(age_reg));

    // lowest matching entry and lowest free entry
    always_comb begin
        hit_found_c  = 1'b0;
        hit_idx_c    = '0;
        free_found_c = 1'b0;
        free_idx_c   = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_found_c = 1'b1;
                hit_idx_c   = IDX_W'(i);
            end
            if (!valid_reg[i]) begin
                free_found_c = 1'b1;
                free_idx_c   = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.look) begin
            hit_found_reg  <= hit_found_c;
            hit_idx_reg    <= hit_idx_c;
            hit_young_reg  <= younger[hit_idx_c];
            hit_len_eq_reg <= len_eq[hit_idx_c];
            free_found_reg <= free_found_c;
            free_idx_reg   <= free_idx_c;
        end
    end

    adf_ram #(
        .WIDTH (PAY_W),
        .DEPTH (N)
    ) u_pay_ram (
        .aclk  (aclk),
        .we    (cmd.write),
        .waddr (slot_reg),
        .wdata (pay_q_reg),
        .re    (cmd.look),
        .raddr (hit_idx_c),
        .rdata (rd_pay)
    );

    // ---------------- status
    assign scan_time     = ent_seen_reg[scan_cnt_reg];
    assign sts.enabled   = en_reg;
    assign sts.dup       = hit_found_reg & hit_young_reg & hit_len_eq_reg & (rd_pay == pay_q_reg);
    assign sts.scan_need = !hit_found_reg && !free_found_reg && (N > 1);
    assign sts.scan_last = (scan_cnt_reg == IDX_W'(N - 1));

    // ---------------- slot choice and oldest-entry scan
    always_ff @(posedge aclk) begin
        if (cmd.cmp) begin
            slot_reg     <= hit_found_reg ? hit_idx_reg : (free_found_reg ? free_idx_reg : '0);
            min_time_reg <= ent_seen_reg[0];
            scan_cnt_reg <= IDX_W'(1);
        end else if (cmd.scan) begin
            // strict compare keeps the lowest index on a tie
            if (scan_time < min_time_reg) begin
                slot_reg     <= scan_cnt_reg;
                min_time_reg <= scan_time;
            end
            scan_cnt_reg <= scan_cnt_reg + IDX_W'(1);
        end
    end

    // ---------------- table update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            last_sweep_reg <= '0;
        end else begin
            if (cmd.clear) begin
                valid_reg <= '0;
            end else if (cmd.sweep && sweep_due) begin
                valid_reg      <= valid_reg & ~older;
                last_sweep_reg <= now_q_reg;
            end else if (cmd.write) begin
                valid_reg[slot_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            ent_addr_reg[slot_reg] <= addr_q_reg;
            ent_len_reg[slot_reg]  <= len_q_reg;
            ent_seen_reg[slot_reg] <= now_q_reg;
        end
    end

endmodule

// ===== rtl/core/advertisement_duplicate_filter.sv =====
// Duplicate filter for received advertisements. One beat in gives one drop flag out.
// An enabled beat passes through capture in the accepting cycle, sweep of aged entries,
// address lookup with payload read from the entry ram, compare, entry write, and the
// result register. A dropped duplicate skips the write. When the table is full and the
// address is new, a scan for the oldest entry runs between compare and write, one entry
// per cycle. With the filter disabled a beat clears the table and goes straight to the
// result register. A result still waiting to be read holds the block in its last state
// until the result register frees up. The next beat is taken as soon as the state
// machine is back to idle, even while the previous result still waits to be read.
`timescale 1ns / 1ps

module advertisement_duplicate_filter #(
    parameter int TABLE_ENTRIES     = 16,
    parameter int MAX_PAYLOAD_BYTES = 31
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [adf_pkg::ADDR_W-1:0]     s_device_address,
    input  logic [adf_pkg::LEN_W-1:0]      s_payload_length,
    input  logic [adf_pkg::WORD_W-1:0]     s_payload_word0,
    input  logic [adf_pkg::WORD_W-1:0]     s_payload_word1,
    input  logic [adf_pkg::WORD_W-1:0]     s_payload_word2,
    input  logic [adf_pkg::WORD_W-1:0]     s_payload_word3,
    input  logic [adf_pkg::TIME_W-1:0]     s_now_us,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_drop,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [adf_pkg::PADDR_W-1:0]    paddr,
    input  logic [adf_pkg::APB_W-1:0]      pwdata,
    output logic [adf_pkg::APB_W-1:0]      prdata,
    output logic                           pready
);

    import adf_pkg::*;

    adf_cmd_t cmd;
    adf_sts_t sts;

    assign pready = 1'b1;

    adf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_drop  (m_drop),
        .cmd     (cmd),
        .sts     (sts)
    );

    adf_dpath #(
        .TABLE_ENTRIES     (TABLE_ENTRIES),
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .s_device_address (s_device_address),
        .s_payload_length (s_payload_length),
        .s_payload_word0  (s_payload_word0),
        .s_payload_word1  (s_payload_word1),
        .s_payload_word2  (s_payload_word2),
        .s_payload_word3  (s_payload_word3),
        .s_now_us         (s_now_us),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata)
    );

endmodule

// ===== sim/tb.sv =====
// self-checking testbench for the advertisement duplicate filter
`timescale 1ns / 1ps

module tb;
    import adf_pkg::*;

    localparam int     TBL_N          = 16;
    localparam int     MAX_BYTES      = 31;
    localparam int     POOL_MAX       = 32;
    localparam int     SETTLE_CYCLES  = 30;
    localparam int     WATCHDOG_LIMIT = 3000;
    localparam int     HOLD_AT        = 850;
    localparam int     HOLD_CYCLES    = 300;
    localparam longint US_PER_S       = longint'(US_PER_SECOND);
    localparam longint TIME_MAX       = longint'(48'hFFFF_FFFF_FFFF);

    typedef struct packed {
        logic [ADDR_W-1:0]      addr;
        logic [LEN_W-1:0]       len;
        logic [3:0][WORD_W-1:0] words;
        logic [TIME_W-1:0]      now;
    } advert_t;

    logic                   aclk             = 1'b0;
    logic                   aresetn          = 1'b0;
    logic                   s_valid          = 1'b0;
    logic                   s_ready;
    logic [ADDR_W-1:0]      s_device_address = '0;
    logic [LEN_W-1:0]       s_payload_length = '0;
    logic [WORD_W-1:0]      s_payload_word0  = '0;
    logic [WORD_W-1:0]      s_payload_word1  = '0;
    logic [WORD_W-1:0]      s_payload_word2  = '0;
    logic [WORD_W-1:0]      s_payload_word3  = '0;
    logic [TIME_W-1:0]      s_now_us         = '0;
    logic                   m_valid;
    logic                   m_ready          = 1'b0;
    logic                   m_drop;
    logic                   psel             = 1'b0;
    logic                   penable          = 1'b0;
    logic                   pwrite           = 1'b0;
    logic [PADDR_W-1:0]     paddr            = '0;
    logic [APB_W-1:0]       pwdata           = '0;
    logic [APB_W-1:0]       prdata;
    logic                   pready;

    // predicted filter state
    logic                   tbl_used  [TBL_N];
    logic [ADDR_W-1:0]      tbl_addr  [TBL_N];
    logic [LEN_W-1:0]       tbl_len   [TBL_N];
    logic [3:0][WORD_W-1:0] tbl_data  [TBL_N];
    logic [TIME_W-1:0]      tbl_stamp [TBL_N];
    logic [TIME_W-1:0]      sweep_stamp;
    logic                   cfg_enable;
    logic [MAXAGE_W-1:0]    cfg_max_age;

    // stimulus pool of advertisers
    logic [ADDR_W-1:0]      pool_addr  [POOL_MAX];
    logic [LEN_W-1:0]       pool_len   [POOL_MAX];
    logic [3:0][WORD_W-1:0] pool_words [POOL_MAX];
    logic [TIME_W-1:0]      pool_stamp [POOL_MAX];
    logic                   pool_sent  [POOL_MAX];
    int                     pool_n;
    logic [TIME_W-1:0]      air_us;

    advert_t advert_q[$];
    logic    drop_expect_q[$];
    advert_t send_ad;
    advert_t seen_ad;
    logic    want_drop;
    logic    beat_taken     = 1'b0;
    int      gap_left       = 0;
    int      burst_left     = 0;
    int      ready_run      = 0;
    int      stall_run      = 0;
    int      long_hold_left = 0;
    logic    long_hold_done = 1'b0;
    int      idle_cycles    = 0;
    int      items_taken    = 0;
    int      results_seen   = 0;
    int      drops_seen     = 0;
    int      settings_cnt   = 0;
    int      fail_cnt       = 0;

    advertisement_duplicate_filter #(
        .TABLE_ENTRIES    (TBL_N),
        .MAX_PAYLOAD_BYTES(MAX_BYTES)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_device_address(s_device_address),
        .s_payload_length(s_payload_length),
        .s_payload_word0 (s_payload_word0),
        .s_payload_word1 (s_payload_word1),
        .s_payload_word2 (s_payload_word2),
        .s_payload_word3 (s_payload_word3),
        .s_now_us        (s_now_us),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drop          (m_drop),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 aclk = ~aclk;

    // bytes of one payload word that lie inside the length
    function automatic logic [WORD_W-1:0] byte_keep(input int len, input int word);
        int n;
        if (len <= word * 8) return '0;
        n = len - word * 8;
        if (n >= 8) return '1;
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    function automatic longint stamp_gap(input logic [TIME_W-1:0] later,
                                         input logic [TIME_W-1:0] earlier);
        return longint'({16'd0, later}) - longint'({16'd0, earlier});
    endfunction

    function automatic logic [3:0][WORD_W-1:0] rand_words();
        logic [3:0][WORD_W-1:0] w;
        for (int i = 0; i < 4; i++) w[i] = {$urandom(), $urandom()};
        return w;
    endfunction

    // decides drop for one advertisement and updates the predicted table
    function automatic logic predict_drop(input advert_t ad);
        logic [3:0][WORD_W-1:0] kept;
        int                     len;
        longint                 limit_us;
        int                     hit;
        int                     slot;
        logic                   same;
        if (!cfg_enable) begin
            for (int i = 0; i < TBL_N; i++) tbl_used[i] = 1'b0;
            return 1'b0;
        end
        len = int'(ad.len);
        if (len > MAX_BYTES) len = MAX_BYTES;
        for (int w = 0; w < 4; w++) kept[w] = ad.words[w] & byte_keep(len, w);
        limit_us = longint'(cfg_max_age) * US_PER_S;

        if (stamp_gap(ad.now, sweep_stamp) > limit_us) begin
            sweep_stamp = ad.now;
            for (int i = 0; i < TBL_N; i++)
                if (tbl_used[i] && stamp_gap(ad.now, tbl_stamp[i]) > limit_us)
                    tbl_used[i] = 1'b0;
        end

        hit = -1;
        for (int i = 0; i < TBL_N; i++) begin
            if (hit < 0 && tbl_used[i] && tbl_addr[i] == ad.addr) hit = i;
        end

        if (hit >= 0 && stamp_gap(ad.now, tbl_stamp[hit]) < limit_us &&
            int'(tbl_len[hit]) == len) begin
            same = 1'b1;
            for (int w = 0; w < 4; w++)
                if (tbl_data[hit][w] != kept[w]) same = 1'b0;
            if (same) return 1'b1;
        end

        slot = hit;
        if (slot < 0) begin
            for (int i = 0; i < TBL_N; i++)
                if (slot < 0 && !tbl_used[i]) slot = i;
        end
        // full table: oldest entry goes, lowest index on a tie
        if (slot < 0) begin
            slot = 0;
            for (int i = 1; i < TBL_N; i++)
                if (tbl_stamp[i] < tbl_stamp[slot]) slot = i;
        end
        tbl_used[slot]  = 1'b1;
        tbl_addr[slot]  = ad.addr;
        tbl_len[slot]   = LEN_W'(len);
        tbl_data[slot]  = kept;
        tbl_stamp[slot] = ad.now;
        return 1'b0;
    endfunction

    task automatic note_failure(input string msg);
        fail_cnt++;
        if (fail_cnt <= 10) $display("mismatch: %s", msg);
    endtask

    task automatic push_advert(input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len,
                               input logic [3:0][WORD_W-1:0] words,
                               input logic [TIME_W-1:0] now);
        advert_t ad;
        ad.addr  = addr;
        ad.len   = len;
        ad.words = words;
        ad.now   = now;
        advert_q.push_back(ad);
    endtask

    task automatic new_pool(input int n);
        pool_n = n;
        for (int i = 0; i < n; i++) begin
            pool_addr[i] = 48'({$urandom(), $urandom()});
            pool_sent[i] = 1'b0;
        end
    endtask

    // mostly repeats from the pool so that duplicates, aging and replacement happen
    task automatic queue_random(input int n);
        advert_t           ad;
        longint            lim;
        longint            nxt;
        int                k;
        int                sel;
        logic [WORD_W-1:0] keep;
        for (int j = 0; j < n; j++) begin
            lim = longint'(cfg_max_age) * US_PER_S;
            k   = ($urandom_range(0, 9) < 8) ? int'($urandom_range(0, pool_n - 1)) : -1;
            nxt = longint'({16'd0, air_us});
            sel = $urandom_range(0, 19);
            if (sel < 8)
                nxt += longint'($urandom_range(0, 2000));
            else if (sel < 11)
                nxt += (lim * longint'($urandom_range(0, 1000))) / 1000;
            else if (sel < 14)
                nxt += lim + 1 + (lim * longint'($urandom_range(0, 1000))) / 1000;
            else if (sel < 16)
                nxt += lim - 1 + longint'($urandom_range(0, 2));
            else if (sel == 16 && k >= 0 && pool_sent[k])
                nxt = longint'({16'd0, pool_stamp[k]}) + lim;
            else if (sel == 17)
                nxt -= longint'($urandom_range(1, 5000)) +
                       (lim * longint'($urandom_range(0, 500))) / 1000;
            if (nxt < 0) nxt = 0;
            if (nxt > TIME_MAX) nxt = TIME_MAX;
            air_us = nxt[TIME_W-1:0];

            ad.words = rand_words();
            ad.len   = LEN_W'($urandom_range(0, 31));
            ad.addr  = (k >= 0) ? pool_addr[k] : 48'({$urandom(), $urandom()});
            ad.now   = air_us;
            if (k >= 0 && pool_sent[k] && $urandom_range(0, 9) < 6) begin
                // same content, fresh junk beyond the length
                ad.len = pool_len[k];
                for (int w = 0; w < 4; w++) begin
                    keep = byte_keep(int'(ad.len), w);
                    ad.words[w] = (pool_words[k][w] & keep) | (ad.words[w] & ~keep);
                end
            end
            if (k >= 0) begin
                pool_len[k]   = ad.len;
                pool_words[k] = ad.words;
                pool_stamp[k] = ad.now;
                pool_sent[k]  = 1'b1;
            end
            advert_q.push_back(ad);
        end
    endtask

    task automatic wait_drained();
        while (advert_q.size() != 0 || s_valid || drop_expect_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic check_register(input logic [REG_IDX_W-1:0] idx);
        logic [APB_W-1:0] rd;
        logic [APB_W-1:0] want;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        rd = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        want = (idx == REG_FILTER_EN) ? APB_W'(cfg_enable) : APB_W'(cfg_max_age);
        if (rd !== want)
            note_failure($sformatf("register %0d read expected %0h, got %0h", idx, want, rd));
    endtask

    // only called with the block idle
    task automatic set_register(input logic [REG_IDX_W-1:0] idx, input logic [APB_W-1:0] val);
        wait_drained();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FILTER_EN: cfg_enable  = val[0];
            REG_MAX_AGE:   cfg_max_age = val[MAXAGE_W-1:0];
            default: ;
        endcase
        settings_cnt++;
        check_register(idx);
    endtask

    // sender: bursts of beats with random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || beat_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (advert_q.size() > 0) begin
                send_ad = advert_q.pop_front();
                s_device_address <= send_ad.addr;
                s_payload_length <= send_ad.len;
                s_payload_word0  <= send_ad.words[0];
                s_payload_word1  <= send_ad.words[1];
                s_payload_word2  <= send_ad.words[2];
                s_payload_word3  <= send_ad.words[3];
                s_now_us         <= send_ad.now;
                s_valid          <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 15);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: own stall pattern plus one long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (long_hold_left > 0) begin
            long_hold_left--;
            m_ready <= 1'b0;
        end else if (!long_hold_done && results_seen >= HOLD_AT) begin
            long_hold_done = 1'b1;
            long_hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (ready_run > 0) begin
            ready_run--;
            m_ready <= 1'b1;
        end else if (stall_run > 0) begin
            stall_run--;
            m_ready <= 1'b0;
        end else begin
            ready_run = $urandom_range(0, 24);
            stall_run = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            m_ready <= 1'b1;
        end
    end

    // input beats feed the predictor, result beats are checked in order
    always @(posedge aclk) begin
        beat_taken = aresetn && s_valid && s_ready;
        if (beat_taken) begin
            seen_ad.addr     = s_device_address;
            seen_ad.len      = s_payload_length;
            seen_ad.words[0] = s_payload_word0;
            seen_ad.words[1] = s_payload_word1;
            seen_ad.words[2] = s_payload_word2;
            seen_ad.words[3] = s_payload_word3;
            seen_ad.now      = s_now_us;
            drop_expect_q.push_back(predict_drop(seen_ad));
            items_taken++;
        end
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_drop === 1'b1) drops_seen++;
            if (drop_expect_q.size() == 0) begin
                note_failure($sformatf("result %0d with nothing expected, drop %0b",
                                       results_seen, m_drop));
            end else begin
                want_drop = drop_expect_q.pop_front();
                if (m_drop !== want_drop)
                    note_failure($sformatf("result %0d: drop expected %0b, got %0b",
                                           results_seen, want_drop, m_drop));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no beat for %0d cycles", idle_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        logic [ADDR_W-1:0]      addr_a;
        logic [3:0][WORD_W-1:0] ones;
        logic [3:0][WORD_W-1:0] w;

        for (int i = 0; i < TBL_N; i++) tbl_used[i] = 1'b0;
        sweep_stamp = '0;
        cfg_enable  = FILTER_EN_RESET;
        cfg_max_age = MAX_AGE_RESET;
        air_us      = '0;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        check_register(REG_FILTER_EN);
        check_register(REG_MAX_AGE);

        // directed part, default age limit of ten seconds
        ones   = '1;
        addr_a = 48'hA5A5_0F0F_1234;
        push_advert(addr_a, 5'd31, ones, 48'd100);
        push_advert(addr_a, 5'd31, ones, 48'd200);
        w = ones;
        w[3][63:56] = 8'h00;                         // byte past the length differs
        push_advert(addr_a, 5'd31, w, 48'd300);
        push_advert(addr_a, 5'd0, rand_words(), 48'd400);
        push_advert(addr_a, 5'd0, rand_words(), 48'd500);
        push_advert('0, 5'd1, '0, 48'd600);
        w = rand_words();
        w[0] = '1;
        push_advert('1, 5'd8, w, 48'd700);
        w = rand_words();
        w[0] = '1;
        push_advert('1, 5'd8, w, 48'd800);
        push_advert(addr_a, 5'd0, rand_words(), 48'd10_000_400);  // age exactly at limit
        push_advert(addr_a, 5'd0, rand_words(), 48'd450);         // time steps back
        push_advert('0, 5'd1, '0, 48'd10_000_601);                // stale but not swept
        // fill the table, then a new address evicts the oldest
        for (int j = 0; j < 14; j++)
            push_advert(48'({$urandom(), $urandom()}), LEN_W'($urandom_range(0, 31)),
                        rand_words(), 48'd10_001_000);
        w = rand_words();
        w[0] = '1;
        push_advert('1, 5'd8, w, 48'd10_002_000);
        air_us = 48'd10_002_000;

        new_pool($urandom_range(4, 28));
        queue_random(230);

        set_register(REG_MAX_AGE, 32'd0);
        new_pool($urandom_range(4, 28));
        queue_random(180);

        set_register(REG_FILTER_EN, 32'd0);
        push_advert(addr_a, 5'd31, ones, air_us);
        push_advert(addr_a, 5'd31, ones, air_us);
        queue_random(60);

        set_register(REG_FILTER_EN, 32'd1);
        set_register(REG_MAX_AGE, 32'd65535);
        new_pool($urandom_range(4, 28));
        queue_random(230);

        set_register(REG_MAX_AGE, 32'd1);
        new_pool($urandom_range(4, 28));
        queue_random(100);

        set_register(REG_MAX_AGE, 32'd2);
        new_pool($urandom_range(4, 28));
        queue_random(230);

        // last setting runs at the top of the time range
        set_register(REG_MAX_AGE, 32'd10);
        air_us = 48'hF000_0000_0000;
        new_pool($urandom_range(4, 28));
        queue_random(240);
        push_advert('1, 5'd31, ones, '1);

        wait_drained();
        if (drop_expect_q.size() != 0)
            note_failure($sformatf("%0d results never arrived", drop_expect_q.size()));
        $display("covered %0d advertisements and %0d results, %0d of them dropped",
                 items_taken, results_seen, drops_seen);
        $display("across %0d register writes, %0d failures", settings_cnt, fail_cnt);
        if (fail_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
